[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/ptf_pkg.sv]
// ----------------------------------------------------------------------------
// ptf_pkg
// Types and constants of the path fan tessellator.
// ----------------------------------------------------------------------------
package ptf_pkg;

   localparam int COORD_W   = 24;
   localparam int IDX_W     = 16;
   localparam int FRAC_BITS = 8;
   localparam int DEV_W     = 28;
   localparam int DIV_W     = 5;

   typedef enum logic [1:0] {
      CMD_MOVE  = 2'd0,
      CMD_LINE  = 2'd1,
      CMD_CUBIC = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      cmd_type   cmd;
      logic      new_path;
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
   } req_item_type;

   typedef struct packed {
      logic      vertex_valid;
      idx_type   vertex_index;
      coord_type vertex_x;
      coord_type vertex_y;
      logic      tri_valid;
      idx_type   tri_first;
      idx_type   tri_prev;
      idx_type   tri_curr;
      logic      dropped;
      logic      last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] fill;
      logic       head_valid;
   } front_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DEV1,
      ST_DEV2,
      ST_SEG1,
      ST_SEG2,
      ST_WGT1,
      ST_WGT2,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_PT
   } back_state_type;

endpackage

[sv/ptf_req_if.sv]
// ----------------------------------------------------------------------------
// ptf_req_if
// Command channel: valid/ready with one path command per beat.
// ----------------------------------------------------------------------------
interface ptf_req_if import ptf_pkg::*; ();
   logic      valid;
   logic      ready;
   logic [1:0] req_type;
   logic      new_path;
   coord_type p0_x;
   coord_type p0_y;
   coord_type p1_x;
   coord_type p1_y;
   coord_type p2_x;
   coord_type p2_y;

   modport source (output valid, req_type, new_path, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                   input ready);
   modport sink (input valid, req_type, new_path, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                 output ready);
endinterface

[sv/ptf_rsp_if.sv]
// ----------------------------------------------------------------------------
// ptf_rsp_if
// Result channel: valid/ready with one vertex/triangle record per beat.
// ----------------------------------------------------------------------------
interface ptf_rsp_if import ptf_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      vertex_valid;
   idx_type   vertex_index;
   coord_type vertex_x;
   coord_type vertex_y;
   logic      tri_valid;
   idx_type   tri_first;
   idx_type   tri_prev;
   idx_type   tri_curr;
   logic      dropped;
   logic      last;

   modport source (output valid, vertex_valid, vertex_index, vertex_x, vertex_y, tri_valid,
                   tri_first, tri_prev, tri_curr, dropped, last, input ready);
   modport sink (input valid, vertex_valid, vertex_index, vertex_x, vertex_y, tri_valid,
                 tri_first, tri_prev, tri_curr, dropped, last, output ready);
endinterface

[sv/ptf_front.sv]
// ----------------------------------------------------------------------------
// ptf_front
// Accepts commands, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ptf_front import ptf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ptf_req_if.sink          req,
   input  logic             pop,
   output req_item_type     head,
   output front_status_type status
);

   req_item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       do_pop;
   req_item_type item;

   always_comb begin
      item.cmd      = cmd_type'(req.req_type);
      item.new_path = req.new_path;
      item.p0_x     = req.p0_x;
      item.p0_y     = req.p0_y;
      item.p1_x     = req.p1_x;
      item.p1_y     = req.p1_y;
      item.p2_x     = req.p2_x;
      item.p2_y     = req.p2_y;
   end

   assign req.ready = (fill_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign do_pop    = pop && (fill_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head              = q_ff[rd_ptr_ff];
   assign status.fill       = fill_ff;
   assign status.head_valid = (fill_ff != 2'd0);

endmodule

[sv/ptf_back.sv]
// ----------------------------------------------------------------------------
// ptf_back
// Executes commands: vertex numbering, fan triangles and cubic flattening.
// ----------------------------------------------------------------------------
module ptf_back import ptf_pkg::*; #(
   parameter int MAX_SEGMENTS = 64,
   parameter int VERTEX_LIMIT = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  req_item_type head,
   output logic         pop,
   ptf_rsp_if.source    rsp
);

   localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
   localparam int W_W   = 3 * SEG_W;
   localparam int WK_W  = W_W + 2;
   localparam int ACC_W = W_W + COORD_W + 3;
   localparam int CNT_W = $clog2(VERTEX_LIMIT + 1);

   back_state_type state_ff, state_in;
   req_item_type   cur_ff, cur_in;
   rsp_item_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             first_ok_ff, first_ok_in;
   logic [CNT_W-1:0] first_ff, first_in;
   logic             prev_ok_ff, prev_ok_in;
   logic [CNT_W-1:0] prev_ff, prev_in;
   coord_type        pen_x_ff, pen_x_in;
   coord_type        pen_y_ff, pen_y_in;

   logic [DEV_W-3:0] dev_ff [4];
   logic [DEV_W-3:0] dev_in [4];
   logic [SEG_W-1:0] n_ff, n_in;
   logic [SEG_W-1:0] s_ff, s_in;
   logic [2*SEG_W-1:0] nn_ff, nn_in;
   logic [W_W-1:0]   d_ff, d_in;
   logic [2*SEG_W-1:0] mm_ff, mm_in;
   logic [2*SEG_W-1:0] ss_ff, ss_in;
   logic [WK_W-1:0]  w_ff [4];
   logic [WK_W-1:0]  w_in [4];
   logic [1:0]       k_ff, k_in;
   logic signed [ACC_W-1:0] acc_x_ff, acc_x_in;
   logic signed [ACC_W-1:0] acc_y_ff, acc_y_in;
   logic [W_W-1:0]   rem_x_ff, rem_x_in;
   logic [W_W-1:0]   rem_y_ff, rem_y_in;
   logic [COORD_W-1:0] low_x_ff, low_x_in;
   logic [COORD_W-1:0] low_y_ff, low_y_in;
   logic [DIV_W-1:0] div_cnt_ff, div_cnt_in;

   logic             out_free;
   logic             full;
   coord_type        pt_x, pt_y;
   rsp_item_type     vtx;
   logic signed [DEV_W-2:0] dt [4];
   logic [DEV_W-1:0] dev_sum;
   logic [DEV_W-1:0] dev_sh;
   logic [SEG_W-1:0] m_val;
   coord_type        cx, cy;
   logic signed [WK_W+COORD_W:0] prod_x, prod_y;
   logic signed [ACC_W-1:0] dvd_x, dvd_y;
   logic [W_W:0]     t_x, t_y;
   logic             ge_x, ge_y;

   assign full = (cnt_ff >= CNT_W'(VERTEX_LIMIT));

   // vertex record for a line point or a cubic point
   always_comb begin
      pt_x = (state_ff == ST_PT) ? coord_type'({~low_x_ff[COORD_W-1], low_x_ff[COORD_W-2:0]})
                                 : cur_ff.p0_x;
      pt_y = (state_ff == ST_PT) ? coord_type'({~low_y_ff[COORD_W-1], low_y_ff[COORD_W-2:0]})
                                 : cur_ff.p0_y;
      vtx = '0;
      if (full) begin
         vtx.dropped = 1'b1;
      end else begin
         vtx.vertex_valid = 1'b1;
         vtx.vertex_index = IDX_W'(cnt_ff);
         vtx.vertex_x     = pt_x;
         vtx.vertex_y     = pt_y;
         if (prev_ok_ff && first_ok_ff) begin
            vtx.tri_valid = 1'b1;
            vtx.tri_first = IDX_W'(first_ff);
            vtx.tri_prev  = IDX_W'(prev_ff);
            vtx.tri_curr  = IDX_W'(cnt_ff);
         end
      end
   end

   // datapath helpers
   always_comb begin
      dt[0] = ((DEV_W-1)'(cur_ff.p0_x) <<< 1) - (DEV_W-1)'(pen_x_ff) - (DEV_W-1)'(cur_ff.p2_x);
      dt[1] = ((DEV_W-1)'(cur_ff.p0_y) <<< 1) - (DEV_W-1)'(pen_y_ff) - (DEV_W-1)'(cur_ff.p2_y);
      dt[2] = ((DEV_W-1)'(cur_ff.p1_x) <<< 1) - (DEV_W-1)'(pen_x_ff) - (DEV_W-1)'(cur_ff.p2_x);
      dt[3] = ((DEV_W-1)'(cur_ff.p1_y) <<< 1) - (DEV_W-1)'(pen_y_ff) - (DEV_W-1)'(cur_ff.p2_y);
      dev_sum = DEV_W'(dev_ff[0]) + DEV_W'(dev_ff[1]) + DEV_W'(dev_ff[2]) + DEV_W'(dev_ff[3]);
      dev_sh  = dev_sum >> (FRAC_BITS - 2);
      m_val   = n_ff - s_ff;
      unique case (k_ff)
         2'd0: begin cx = pen_x_ff;    cy = pen_y_ff;    end
         2'd1: begin cx = cur_ff.p0_x; cy = cur_ff.p0_y; end
         2'd2: begin cx = cur_ff.p1_x; cy = cur_ff.p1_y; end
         default: begin cx = cur_ff.p2_x; cy = cur_ff.p2_y; end
      endcase
      prod_x = $signed({1'b0, w_ff[k_ff]}) * cx;
      prod_y = $signed({1'b0, w_ff[k_ff]}) * cy;
      // bias by half the divisor for rounding and by 2^23 divisors to stay non-negative
      dvd_x = acc_x_ff + ACC_W'(d_ff >> 1) + (ACC_W'(d_ff) << (COORD_W - 1));
      dvd_y = acc_y_ff + ACC_W'(d_ff >> 1) + (ACC_W'(d_ff) << (COORD_W - 1));
      t_x   = {rem_x_ff, low_x_ff[COORD_W-1]};
      t_y   = {rem_y_ff, low_y_ff[COORD_W-1]};
      ge_x  = (t_x >= {1'b0, d_ff});
      ge_y  = (t_y >= {1'b0, d_ff});
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      rsp_in      = rsp_ff;
      cnt_in      = cnt_ff;
      first_ok_in = first_ok_ff;
      first_in    = first_ff;
      prev_ok_in  = prev_ok_ff;
      prev_in     = prev_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      dev_in      = dev_ff;
      n_in        = n_ff;
      s_in        = s_ff;
      nn_in       = nn_ff;
      d_in        = d_ff;
      mm_in       = mm_ff;
      ss_in       = ss_ff;
      w_in        = w_ff;
      k_in        = k_ff;
      acc_x_in    = acc_x_ff;
      acc_y_in    = acc_y_ff;
      rem_x_in    = rem_x_ff;
      rem_y_in    = rem_y_ff;
      low_x_in    = low_x_ff;
      low_y_in    = low_y_ff;
      div_cnt_in  = div_cnt_ff;
      pop         = 1'b0;
      out_free    = !rsp_valid_ff || rsp.ready;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.new_path) begin
                  first_ok_in = 1'b0;
                  prev_ok_in  = 1'b0;
                  pen_x_in    = '0;
                  pen_y_in    = '0;
               end
               state_in = (head.cmd == CMD_CUBIC) ? ST_DEV1 : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               unique case (cur_ff.cmd)
                  CMD_MOVE: begin
                     rsp_in = '0;
                     if (full) begin
                        rsp_in.dropped = 1'b1;
                        first_ok_in    = 1'b0;
                     end else begin
                        rsp_in.vertex_valid = 1'b1;
                        rsp_in.vertex_index = IDX_W'(cnt_ff);
                        rsp_in.vertex_x     = cur_ff.p0_x;
                        rsp_in.vertex_y     = cur_ff.p0_y;
                        first_ok_in         = 1'b1;
                        first_in            = cnt_ff;
                        cnt_in              = cnt_ff + 1'b1;
                     end
                     prev_ok_in = 1'b0;
                     pen_x_in   = cur_ff.p0_x;
                     pen_y_in   = cur_ff.p0_y;
                  end
                  CMD_LINE: begin
                     rsp_in = vtx;
                     if (!full) begin
                        prev_ok_in = 1'b1;
                        prev_in    = cnt_ff;
                        cnt_in     = cnt_ff + 1'b1;
                        pen_x_in   = cur_ff.p0_x;
                        pen_y_in   = cur_ff.p0_y;
                     end
                  end
                  default: begin
                     // close: degenerate triangle back to the subpath start
                     rsp_in = '0;
                     if (prev_ok_ff && first_ok_ff && (prev_ff != first_ff)) begin
                        rsp_in.tri_valid = 1'b1;
                        rsp_in.tri_first = IDX_W'(first_ff);
                        rsp_in.tri_prev  = IDX_W'(prev_ff);
                        rsp_in.tri_curr  = IDX_W'(first_ff);
                     end
                     prev_ok_in = 1'b0;
                  end
               endcase
               rsp_in.last = 1'b1;
            end
         end
         ST_DEV1: begin
            for (int i = 0; i < 4; i++) begin
               dev_in[i] = dt[i][DEV_W-2] ? (DEV_W-2)'(-dt[i]) : (DEV_W-2)'(dt[i]);
            end
            state_in = ST_DEV2;
         end
         ST_DEV2: begin
            priority if (dev_sh >= DEV_W'(MAX_SEGMENTS)) begin
               n_in = SEG_W'(MAX_SEGMENTS);
            end else if (dev_sh == '0) begin
               n_in = SEG_W'(2);
            end else begin
               n_in = SEG_W'(dev_sh) + 1'b1;
            end
            state_in = ST_SEG1;
         end
         ST_SEG1: begin
            nn_in    = n_ff * n_ff;
            state_in = ST_SEG2;
         end
         ST_SEG2: begin
            d_in     = W_W'(nn_ff * n_ff);
            s_in     = SEG_W'(1);
            state_in = ST_WGT1;
         end
         ST_WGT1: begin
            mm_in    = m_val * m_val;
            ss_in    = s_ff * s_ff;
            state_in = ST_WGT2;
         end
         ST_WGT2: begin
            w_in[0]  = WK_W'(mm_ff * m_val);
            w_in[1]  = (WK_W'(mm_ff * s_ff) << 1) + WK_W'(mm_ff * s_ff);
            w_in[2]  = (WK_W'(ss_ff * m_val) << 1) + WK_W'(ss_ff * m_val);
            w_in[3]  = WK_W'(ss_ff * s_ff);
            k_in     = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_x_in = ((k_ff == 2'd0) ? ACC_W'(0) : acc_x_ff) + ACC_W'(prod_x);
            acc_y_in = ((k_ff == 2'd0) ? ACC_W'(0) : acc_y_ff) + ACC_W'(prod_y);
            k_in     = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_x_in   = dvd_x[W_W+COORD_W-1:COORD_W];
            rem_y_in   = dvd_y[W_W+COORD_W-1:COORD_W];
            low_x_in   = dvd_x[COORD_W-1:0];
            low_y_in   = dvd_y[COORD_W-1:0];
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_x_in   = ge_x ? W_W'(t_x - {1'b0, d_ff}) : W_W'(t_x);
            rem_y_in   = ge_y ? W_W'(t_y - {1'b0, d_ff}) : W_W'(t_y);
            low_x_in   = {low_x_ff[COORD_W-2:0], ge_x};
            low_y_in   = {low_y_ff[COORD_W-2:0], ge_y};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_W'(COORD_W - 1)) begin
               state_in = ST_PT;
            end
         end
         ST_PT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = vtx;
               rsp_in.last  = full || (s_ff == n_ff);
               if (!full) begin
                  prev_ok_in = 1'b1;
                  prev_in    = cnt_ff;
                  cnt_in     = cnt_ff + 1'b1;
               end
               if (full || (s_ff == n_ff)) begin
                  pen_x_in = cur_ff.p2_x;
                  pen_y_in = cur_ff.p2_y;
                  state_in = ST_IDLE;
               end else begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_WGT1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         first_ok_ff  <= 1'b0;
         prev_ok_ff   <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         first_ok_ff  <= first_ok_in;
         prev_ok_ff   <= prev_ok_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      rsp_ff     <= rsp_in;
      first_ff   <= first_in;
      prev_ff    <= prev_in;
      dev_ff     <= dev_in;
      n_ff       <= n_in;
      s_ff       <= s_in;
      nn_ff      <= nn_in;
      d_ff       <= d_in;
      mm_ff      <= mm_in;
      ss_ff      <= ss_in;
      w_ff       <= w_in;
      k_ff       <= k_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      low_x_ff   <= low_x_in;
      low_y_ff   <= low_y_in;
      div_cnt_ff <= div_cnt_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.vertex_valid = rsp_ff.vertex_valid;
   assign rsp.vertex_index = rsp_ff.vertex_index;
   assign rsp.vertex_x     = rsp_ff.vertex_x;
   assign rsp.vertex_y     = rsp_ff.vertex_y;
   assign rsp.tri_valid    = rsp_ff.tri_valid;
   assign rsp.tri_first    = rsp_ff.tri_first;
   assign rsp.tri_prev     = rsp_ff.tri_prev;
   assign rsp.tri_curr     = rsp_ff.tri_curr;
   assign rsp.dropped      = rsp_ff.dropped;
   assign rsp.last         = rsp_ff.last;

endmodule

[sv/path_fan_tessellator_core.sv]
// ----------------------------------------------------------------------------
// path_fan_tessellator_core
// Fan tessellation of a path: numbered vertices and fan triangles per command.
// ----------------------------------------------------------------------------
//  channel   | dir | beat carries
//  req_bus   | in  | one path command (move, line, cubic, close) with its points
//  rsp_bus   | out | one vertex and/or fan triangle record, last on the final one
//
//  Move, line and close are handled in the back by taking the command from the
//  queue, then loading the result register. A cubic is set up (queue pop,
//  deviation, segment count N, N^3), then each flattened point is weighted,
//  accumulated and divided by N^3 in a bit-serial divider; N runs from
//  2 to MAX_SEGMENTS.
//  Reset is synchronous, active high, and clears the counter, subpath and pen.
//  A result that has not been taken holds the back in its emit or point step;
//  the two-entry command queue lets the front keep accepting beats until full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module path_fan_tessellator_core import ptf_pkg::*; #(
   parameter int MAX_SEGMENTS = 64,
   parameter int VERTEX_LIMIT = 65536
) (
   input  logic      clock,
   input  logic      reset,
   ptf_req_if.sink   req_bus,
   ptf_rsp_if.source rsp_bus
);

   req_item_type     head;
   front_status_type front_status;
   logic             pop;

   // front: accept and decode, hold up to two commands
   ptf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .pop    (pop),
      .head   (head),
      .status (front_status)
   );

   // back: execute one command at a time, drive the result register
   ptf_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .VERTEX_LIMIT (VERTEX_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (front_status.head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

   // a new vertex closing a triangle is always that triangle's third corner
   `ASSERT_SAME(a_tri_curr, clock, reset,
                rsp_bus.valid && rsp_bus.vertex_valid && rsp_bus.tri_valid,
                rsp_bus.tri_curr == rsp_bus.vertex_index)
   // a lost vertex never carries vertex or triangle data
   `ASSERT_SAME(a_drop_clean, clock, reset, rsp_bus.valid && rsp_bus.dropped,
                !rsp_bus.vertex_valid && !rsp_bus.tri_valid)
   // a full queue must hold off the command side
   `ASSERT_SAME(a_queue_full, clock, reset, front_status.fill == 2'd2, !req_bus.ready)
   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid)

endmodule

[test/ptf_tb_channels.sv]
// ----------------------------------------------------------------------------
// ptf_tb_channels
// Stimulus record for the tessellator bench.
// ----------------------------------------------------------------------------
// The block's own channel interfaces are ptf_req_if and ptf_rsp_if. This file
// only collects the stimulus record used by the bench.
package ptf_tb_types;
   import ptf_pkg::*;

   typedef struct {
      cmd_type   cmd;
      logic      new_path;
      coord_type ax, ay, bx, by, ex, ey;
   } path_cmd_type;
endpackage

[test/path_fan_tessellator_core_tb.sv]
// ----------------------------------------------------------------------------
// path_fan_tessellator_core_tb
// Drives path commands into the fan tessellator and checks every result beat
// against a cycle-free predictor of vertex numbering, cubic flattening and fan
// triangles, under several idling patterns on both channels.
// ----------------------------------------------------------------------------
module path_fan_tessellator_core_tb;
   import ptf_pkg::*;
   import ptf_tb_types::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEG_CAP    = 64;
   localparam int VERT_LIMIT = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptf_req_if req_bus ();
   ptf_rsp_if rsp_bus ();

   path_fan_tessellator_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always #10 clock = ~clock;

   // predictor state
   int unsigned vtx_count;
   bit          first_ok, prev_ok;
   int unsigned start_vtx, tail_vtx;
   longint      pen_x, pen_y;

   rsp_item_type expected_beats[$];
   int  fail_count;
   int  beats_seen;
   int  cmds_sent;
   int  cubics_sent;
   int  sender_idle_pct;
   int  receiver_stall_pct;

   // drive every input to a known value from time zero
   initial begin
      req_bus.valid    = 1'b0;
      req_bus.req_type = CMD_MOVE;
      req_bus.new_path = 1'b0;
      req_bus.p0_x = '0; req_bus.p0_y = '0;
      req_bus.p1_x = '0; req_bus.p1_y = '0;
      req_bus.p2_x = '0; req_bus.p2_y = '0;
      rsp_bus.ready    = 1'b0;
   end

   function automatic longint floor_quot(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   // point s of N on the cubic, rounded half up
   function automatic coord_type curve_coord(longint a, longint b, longint c, longint e,
                                             longint s, longint n);
      longint m, d, num;
      m   = n - s;
      d   = n * n * n;
      num = m*m*m*a + 3*m*m*s*b + 3*m*s*s*c + s*s*s*e;
      return coord_type'(floor_quot(num + d / 2, d));
   endfunction

   function automatic longint abs_l(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic rsp_item_type beat_of(bit vv, int unsigned vi, coord_type x,
                                             coord_type y, bit tv, int unsigned ta,
                                             int unsigned tb, int unsigned tc, bit drop);
      rsp_item_type r;
      r = '0;
      r.vertex_valid = vv;
      if (vv) begin
         r.vertex_index = idx_type'(vi);
         r.vertex_x = x;
         r.vertex_y = y;
      end
      r.tri_valid = tv;
      if (tv) begin
         r.tri_first = idx_type'(ta);
         r.tri_prev  = idx_type'(tb);
         r.tri_curr  = idx_type'(tc);
      end
      r.dropped = drop;
      return r;
   endfunction

   // store one vertex with its fan triangle; returns 0 if the store is full
   function automatic bit store_vertex(coord_type x, coord_type y);
      int unsigned idx;
      if (vtx_count >= VERT_LIMIT) begin
         expected_beats.push_back(beat_of(0, 0, 0, 0, 0, 0, 0, 0, 1));
         return 1'b0;
      end
      idx = vtx_count++;
      expected_beats.push_back(beat_of(1, idx, x, y, prev_ok && first_ok,
                                       start_vtx, tail_vtx, idx, 0));
      prev_ok  = 1'b1;
      tail_vtx = idx;
      return 1'b1;
   endfunction

   // work out the result beats of one command and queue them
   function automatic void predict_command(path_cmd_type c);
      longint dev, segs;
      coord_type x, y;
      bit tv;
      if (c.new_path) begin
         first_ok = 0; start_vtx = 0; prev_ok = 0; tail_vtx = 0;
         pen_x = 0; pen_y = 0;
      end
      case (c.cmd)
         CMD_MOVE: begin
            if (vtx_count >= VERT_LIMIT) begin
               expected_beats.push_back(beat_of(0, 0, 0, 0, 0, 0, 0, 0, 1));
               first_ok = 0; start_vtx = 0;
            end else begin
               start_vtx = vtx_count++;
               first_ok  = 1;
               expected_beats.push_back(beat_of(1, start_vtx, c.ax, c.ay, 0, 0, 0, 0, 0));
            end
            prev_ok = 0; tail_vtx = 0;
            pen_x = c.ax; pen_y = c.ay;
         end
         CMD_LINE: begin
            if (store_vertex(c.ax, c.ay)) begin
               pen_x = c.ax; pen_y = c.ay;
            end
         end
         CMD_CUBIC: begin
            dev = abs_l(2*longint'(c.ax) - pen_x - c.ex) + abs_l(2*longint'(c.ay) - pen_y - c.ey)
                + abs_l(2*longint'(c.bx) - pen_x - c.ex) + abs_l(2*longint'(c.by) - pen_y - c.ey);
            segs = (dev >>> (FRAC_BITS - 2)) + 1;
            if (segs > SEG_CAP) segs = SEG_CAP;
            if (segs < 2) segs = 2;
            for (longint s = 1; s <= segs; s++) begin
               x = curve_coord(pen_x, c.ax, c.bx, c.ex, s, segs);
               y = curve_coord(pen_y, c.ay, c.by, c.ey, s, segs);
               if (!store_vertex(x, y)) break;
            end
            pen_x = c.ex; pen_y = c.ey;
         end
         default: begin
            tv = prev_ok && first_ok && tail_vtx != start_vtx;
            expected_beats.push_back(beat_of(0, 0, 0, 0, tv, start_vtx, tail_vtx,
                                             start_vtx, 0));
            prev_ok = 0; tail_vtx = 0;
         end
      endcase
      expected_beats[$].last = 1'b1;
   endfunction

   // send one command: random idle gap, then hold valid until accepted
   task automatic send_command(path_cmd_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= c.cmd;
      req_bus.new_path <= c.new_path;
      req_bus.p0_x <= c.ax; req_bus.p0_y <= c.ay;
      req_bus.p1_x <= c.bx; req_bus.p1_y <= c.by;
      req_bus.p2_x <= c.ex; req_bus.p2_y <= c.ey;
      do @(posedge clock); while (!req_bus.ready);
      predict_command(c);
      cmds_sent++;
      if (c.cmd == CMD_CUBIC) cubics_sent++;
      @(negedge clock);
   endtask

   function automatic path_cmd_type make_cmd(cmd_type t, bit np, coord_type ax,
                                             coord_type ay, coord_type bx = 0,
                                             coord_type by = 0, coord_type ex = 0,
                                             coord_type ey = 0);
      path_cmd_type c;
      c.cmd = t; c.new_path = np;
      c.ax = ax; c.ay = ay; c.bx = bx; c.by = by; c.ex = ex; c.ey = ey;
      return c;
   endfunction

   // coordinate near a centre, mostly small so cubics stay short
   function automatic coord_type near_coord(int spread);
      return coord_type'($signed($urandom_range(2*spread)) - spread);
   endfunction

   function automatic coord_type wide_coord();
      return coord_type'($urandom());
   endfunction

   // hold the ready low at random, with the stall rate of the current phase
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '0;
         got.vertex_valid = rsp_bus.vertex_valid;
         got.vertex_index = rsp_bus.vertex_index;
         got.vertex_x     = rsp_bus.vertex_x;
         got.vertex_y     = rsp_bus.vertex_y;
         got.tri_valid    = rsp_bus.tri_valid;
         got.tri_first    = rsp_bus.tri_first;
         got.tri_prev     = rsp_bus.tri_prev;
         got.tri_curr     = rsp_bus.tri_curr;
         got.dropped      = rsp_bus.dropped;
         got.last         = rsp_bus.last;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // field extremes, every command, close cases, new_path
   task automatic test_directed();
      coord_type mx, mn;
      mx = 24'sh7FFFFF; mn = 24'sh800000;
      send_command(make_cmd(CMD_CLOSE, 1, 0, 0));            // close with nothing
      send_command(make_cmd(CMD_LINE, 0, mx, mn));           // line with no subpath
      send_command(make_cmd(CMD_MOVE, 1, mn, mx));
      send_command(make_cmd(CMD_CLOSE, 0, 0, 0));            // close right after move
      send_command(make_cmd(CMD_MOVE, 0, 0, 0));
      send_command(make_cmd(CMD_LINE, 0, mx, mx));
      send_command(make_cmd(CMD_LINE, 0, mn, mn));
      send_command(make_cmd(CMD_CLOSE, 0, 0, 0));            // fan close
      send_command(make_cmd(CMD_CLOSE, 0, 0, 0));            // close twice
      send_command(make_cmd(CMD_LINE, 0, 256, -256));        // line after close
      // flat cubic: minimum of two segments
      send_command(make_cmd(CMD_CUBIC, 0, 256, -256, 256, -256, 256, -256));
      // tiny bend, few segments
      send_command(make_cmd(CMD_CUBIC, 0, 300, 0, 500, 90, 600, 0));
      // extreme controls: capped at the maximum segment count
      send_command(make_cmd(CMD_CUBIC, 1, mx, mn, mn, mx, mx, mx));
      send_command(make_cmd(CMD_CUBIC, 0, mn, mn, mn, mn, mn, mn));
      send_command(make_cmd(CMD_CUBIC, 1, -1, -1, 1, 1, -3, 3));   // rounding near zero
      send_command(make_cmd(CMD_CLOSE, 0, 0, 0));
      send_command(make_cmd(CMD_MOVE, 1, -5, 7));
      send_command(make_cmd(CMD_CUBIC, 0, -100, 70, 33, -2, 9, 1));
      send_command(make_cmd(CMD_CLOSE, 1, 0, 0));            // new_path on close
   endtask

   // random paths: mostly well formed subpaths, some noise
   task automatic test_random_paths(int count);
      path_cmd_type c;
      int pick, spread;
      for (int i = 0; i < count; i++) begin
         pick   = $urandom_range(99);
         spread = ($urandom_range(9) == 0) ? 8388607 : 2048;
         if (spread > 2048) begin
            c = make_cmd(cmd_type'($urandom_range(3)), $urandom_range(1),
                         wide_coord(), wide_coord(), wide_coord(), wide_coord(),
                         wide_coord(), wide_coord());
         end else if (pick < 15)
            c = make_cmd(CMD_MOVE, $urandom_range(3) == 0, near_coord(spread),
                         near_coord(spread), near_coord(spread), near_coord(spread));
         else if (pick < 55)
            c = make_cmd(CMD_LINE, $urandom_range(19) == 0, near_coord(spread),
                         near_coord(spread), wide_coord(), wide_coord(), wide_coord(),
                         wide_coord());
         else if (pick < 80)
            c = make_cmd(CMD_CUBIC, $urandom_range(19) == 0, near_coord(spread),
                         near_coord(spread), near_coord(spread), near_coord(spread),
                         near_coord(spread), near_coord(spread));
         else
            c = make_cmd(CMD_CLOSE, $urandom_range(9) == 0, wide_coord(), wide_coord(),
                         wide_coord(), wide_coord(), wide_coord(), wide_coord());
         send_command(c);
      end
   endtask

   // drop valid, wait for all expected beats, then drain for the longest cubic point
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      test_random_paths(count);
   endtask

   initial begin
      fail_count = 0; beats_seen = 0; cmds_sent = 0; cubics_sent = 0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      vtx_count = 0; first_ok = 0; prev_ok = 0; start_vtx = 0; tail_vtx = 0;
      pen_x = 0; pen_y = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      run_phase(0, 0, 100);     // no idling
      run_phase(54, 0, 100);    // sender gaps
      run_phase(0, 54, 100);    // receiver stalls
      run_phase(36, 36, 100);   // both
      wait_drained();

      $display("Covered %0d commands over four idling phases: %0d result beats,",
               cmds_sent, beats_seen);
      $display("%0d cubics flattened, %0d vertices numbered", cubics_sent, vtx_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // overall limit: 420 commands at up to 64 points each, with wide room for stalls
   initial begin
      #(420 * 64 * 160 * 20ns);
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/ptf_pkg.sv
sv/ptf_req_if.sv
sv/ptf_rsp_if.sv
sv/ptf_front.sv
sv/ptf_back.sv
sv/path_fan_tessellator_core.sv
test/ptf_tb_channels.sv
test/path_fan_tessellator_core_tb.sv
